// File: rtl/rsb_pkg.sv
// ============================================================================
// rsb_pkg: shared types and constants of the rotated sprite blitter
// Configuration register map, register file struct and field widths.
// ============================================================================
`default_nettype none

package rsb_pkg;

	// Defaults for the top-level parameters.
	localparam int MAX_SPRITE_DEF = 256;
	localparam int ADDR_WIDTH_DEF = 24;

	// Fixed field widths.
	localparam int POS_W    = 13;
	localparam int COORD_W  = 12;
	localparam int STRIDE_W = 14;
	localparam int BPP_W    = 3;
	localparam int DIMREG_W = 9;
	localparam int COLOR_W  = 32;
	localparam int PROD_W   = COORD_W + STRIDE_W + 1;
	localparam int PADDR_W  = 5;
	localparam int PDATA_W  = 32;

	// Command codes of an input beat.
	localparam logic CMD_BEGIN = 1'b0;
	localparam logic CMD_PIXEL = 1'b1;

	// Register indexes, one word apart on the bus.
	typedef enum logic [2:0] {
		REG_SCREEN_W = 3'd0,
		REG_SCREEN_H = 3'd1,
		REG_STRIDE   = 3'd2,
		REG_BPP      = 3'd3,
		REG_SPRITE_W = 3'd4,
		REG_SPRITE_H = 3'd5,
		REG_KEY      = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [COORD_W-1:0]  disp_width;
		logic [COORD_W-1:0]  disp_height;
		logic [STRIDE_W-1:0] line_stride_bytes;
		logic [BPP_W-1:0]    pixel_bytes;
		logic [DIMREG_W-1:0] sprite_width;
		logic [DIMREG_W-1:0] sprite_height;
		logic [COLOR_W-1:0]  transparent_color;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		disp_width:        12'd1024,
		disp_height:       12'd768,
		line_stride_bytes: 14'd4096,
		pixel_bytes:       3'd4,
		sprite_width:      9'd16,
		sprite_height:     9'd16,
		transparent_color: 32'd0
	};

endpackage

`default_nettype wire

// File: rtl/rsb_if.sv
// ============================================================================
// rsb_if: stream channels of the rotated sprite blitter
// Source pixel/command channel and framebuffer write channel.
// ============================================================================
`default_nettype none

interface rsb_in_if;
	logic               valid;
	logic               ready;
	logic               cmd;
	logic signed [12:0] pos_x;
	logic signed [12:0] pos_y;
	logic [1:0]         turn;
	logic [31:0]        pixel_color;

	modport source (output valid, cmd, pos_x, pos_y, turn, pixel_color, input ready);
	modport sink   (input valid, cmd, pos_x, pos_y, turn, pixel_color, output ready);
endinterface

interface rsb_out_if #(
	parameter int ADDR_WIDTH = 24
);
	logic                  valid;
	logic                  ready;
	logic                  write_enable;
	logic [ADDR_WIDTH-1:0] write_addr;
	logic [31:0]           write_data;
	logic                  last_pixel;

	modport source (output valid, write_enable, write_addr, write_data, last_pixel,
		input ready);
	modport sink   (input valid, write_enable, write_addr, write_data, last_pixel,
		output ready);
endinterface

`default_nettype wire

// File: rtl/rsb_cfg.sv
// ============================================================================
// rsb_cfg: configuration register file
// APB-style write and read access to the seven blitter registers.
// ============================================================================
`default_nettype none

module rsb_cfg
	import rsb_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	output cfg_t                    cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (wr) begin
			case (idx)
				REG_SCREEN_W: cfg_q.disp_width        <= pwdata[COORD_W-1:0];
				REG_SCREEN_H: cfg_q.disp_height       <= pwdata[COORD_W-1:0];
				REG_STRIDE:   cfg_q.line_stride_bytes <= pwdata[STRIDE_W-1:0];
				REG_BPP:      cfg_q.pixel_bytes       <= pwdata[BPP_W-1:0];
				REG_SPRITE_W: cfg_q.sprite_width      <= pwdata[DIMREG_W-1:0];
				REG_SPRITE_H: cfg_q.sprite_height     <= pwdata[DIMREG_W-1:0];
				REG_KEY:      cfg_q.transparent_color <= pwdata[COLOR_W-1:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_SCREEN_W: prdata = PDATA_W'(cfg_q.disp_width);
			REG_SCREEN_H: prdata = PDATA_W'(cfg_q.disp_height);
			REG_STRIDE:   prdata = PDATA_W'(cfg_q.line_stride_bytes);
			REG_BPP:      prdata = PDATA_W'(cfg_q.pixel_bytes);
			REG_SPRITE_W: prdata = PDATA_W'(cfg_q.sprite_width);
			REG_SPRITE_H: prdata = PDATA_W'(cfg_q.sprite_height);
			REG_KEY:      prdata = PDATA_W'(cfg_q.transparent_color);
			default:      prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/rotated_sprite_blitter_unit.sv
// ============================================================================
// rotated_sprite_blitter_unit: quarter-turn sprite blitter with colour key
// Maps a raster stream of source pixels to clipped framebuffer writes.
// ============================================================================
//
//  Channel  Direction  Beat contents
//  -------  ---------  ---------------------------------------------------
//  src      in         cmd, pos_x, pos_y, turn, pixel_color
//  dst      out        write_enable, write_addr, write_data, last_pixel
//  APB      in/out     register writes and reads, pready tied high
//
// Every accepted beat yields exactly one result beat, registered in stage one,
// then stage two; one beat can be taken every clock unless the output stalls.
// The first stage computes the rotated screen position, the clip test and the
// colour key test; the second forms row * stride + column * pixel size.
// Reset clears the raster counters, the sprite centre, the rotation and the
// pipeline valid flags, and loads the register defaults.
// A stalled output holds both stages; src stays ready while stage one is free.
//
`default_nettype none

module rotated_sprite_blitter_unit
	import rsb_pkg::*;
#(
	parameter int MAX_SPRITE = MAX_SPRITE_DEF,
	parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	rsb_in_if.sink                  src,
	rsb_out_if.source               dst,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready
);

	// Raster counter width, clamped dimension width and coordinate widths.
	localparam int CNT_W  = $clog2(MAX_SPRITE);
	localparam int DIM_W  = (CNT_W + 1 > DIMREG_W) ? CNT_W + 1 : DIMREG_W;
	localparam int OFS_W  = DIM_W + 1;
	localparam int XW     = ((POS_W > OFS_W) ? POS_W : OFS_W) + 1;
	localparam int SUM_W  = (ADDR_WIDTH > PROD_W) ? ADDR_WIDTH : PROD_W;

	cfg_t cfg;

	rsb_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Sprite state.
	logic [CNT_W-1:0]        col_q, row_q;
	logic signed [POS_W-1:0] centre_x_q, centre_y_q;
	logic [1:0]              rot_q;

	// Pipeline registers.
	logic               v_s1, we_s1, last_s1;
	logic [COORD_W-1:0] x_s1, y_s1;
	logic [COLOR_W-1:0] data_s1;
	logic [BPP_W-1:0]   bpp_s1;

	logic                  v_s2, we_s2, last_s2;
	logic [ADDR_WIDTH-1:0] addr_s2;
	logic [COLOR_W-1:0]    data_s2;

	logic advance, accept;

	assign advance   = !v_s2 || dst.ready;
	assign src.ready = !v_s1 || advance;
	assign accept    = src.valid && src.ready;

	// ------------------------------------------------------------------
	// Stage one: clamped sizes, rotated position, clip and key tests.
	// ------------------------------------------------------------------
	logic [DIM_W-1:0]        w_c, h_c, sw_ext, sh_ext, max_dim;
	logic [BPP_W-1:0]        bpp_c;
	logic [COLOR_W-1:0]      color_m;
	logic signed [OFS_W-1:0] vx, vy;
	logic signed [XW-1:0]    dx, dy;
	logic                    on_screen, pix_we;
	logic                    row_end, sprite_end;

	assign max_dim = DIM_W'(MAX_SPRITE);
	assign sw_ext  = DIM_W'(cfg.sprite_width);
	assign sh_ext  = DIM_W'(cfg.sprite_height);

	always_comb begin
		if (sw_ext == '0) begin
			w_c = DIM_W'(1);
		end else if (sw_ext > max_dim) begin
			w_c = max_dim;
		end else begin
			w_c = sw_ext;
		end
		if (sh_ext == '0) begin
			h_c = DIM_W'(1);
		end else if (sh_ext > max_dim) begin
			h_c = max_dim;
		end else begin
			h_c = sh_ext;
		end

		if (cfg.pixel_bytes < BPP_W'(2)) begin
			bpp_c = BPP_W'(2);
		end else if (cfg.pixel_bytes > BPP_W'(4)) begin
			bpp_c = BPP_W'(4);
		end else begin
			bpp_c = cfg.pixel_bytes;
		end

		case (bpp_c)
			BPP_W'(2): color_m = {16'd0, src.pixel_color[15:0]};
			BPP_W'(3): color_m = {8'd0, src.pixel_color[23:0]};
			default:   color_m = src.pixel_color;
		endcase

		// Offset of the current source pixel from the sprite pivot.
		vx = $signed({1'b0, DIM_W'(col_q)}) - $signed({1'b0, w_c >> 1});
		vy = $signed({1'b0, DIM_W'(row_q)}) - $signed({1'b0, h_c >> 1});

		case (rot_q)
			2'd1: begin
				dx = XW'(centre_x_q) - XW'(vy);
				dy = XW'(centre_y_q) + XW'(vx);
			end
			2'd2: begin
				dx = XW'(centre_x_q) - XW'(vx);
				dy = XW'(centre_y_q) - XW'(vy);
			end
			2'd3: begin
				dx = XW'(centre_x_q) + XW'(vy);
				dy = XW'(centre_y_q) - XW'(vx);
			end
			default: begin
				dx = XW'(centre_x_q) + XW'(vx);
				dy = XW'(centre_y_q) + XW'(vy);
			end
		endcase

		on_screen = !dx[XW-1] && !dy[XW-1]
			&& (dx[XW-2:0] < (XW-1)'(cfg.disp_width))
			&& (dy[XW-2:0] < (XW-1)'(cfg.disp_height));
		pix_we = on_screen && (color_m != cfg.transparent_color);

		// A counter at or past the last column or row ends that row or sprite.
		row_end    = (DIM_W'(col_q) + DIM_W'(1)) >= w_c;
		sprite_end = row_end && ((DIM_W'(row_q) + DIM_W'(1)) >= h_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			centre_x_q <= '0;
			centre_y_q <= '0;
			rot_q      <= '0;
		end else if (accept) begin
			if (src.cmd == CMD_BEGIN) begin
				centre_x_q <= src.pos_x;
				centre_y_q <= src.pos_y;
				rot_q      <= src.turn;
				col_q      <= '0;
				row_q      <= '0;
			end else if (row_end) begin
				col_q <= '0;
				row_q <= sprite_end ? '0 : row_q + CNT_W'(1);
			end else begin
				col_q <= col_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (src.ready) begin
			v_s1 <= src.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (src.cmd == CMD_PIXEL) begin
				we_s1   <= pix_we;
				last_s1 <= sprite_end;
				data_s1 <= pix_we ? color_m : '0;
			end else begin
				we_s1   <= 1'b0;
				last_s1 <= 1'b0;
				data_s1 <= '0;
			end
			x_s1   <= dx[COORD_W-1:0];
			y_s1   <= dy[COORD_W-1:0];
			bpp_s1 <= bpp_c;
		end
	end

	// ------------------------------------------------------------------
	// Stage two: framebuffer byte address, wrapped to the address width.
	// ------------------------------------------------------------------
	logic [SUM_W-1:0] addr_full;

	assign addr_full = SUM_W'(y_s1) * SUM_W'(cfg.line_stride_bytes)
		+ SUM_W'(x_s1) * SUM_W'(bpp_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (advance) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && v_s1) begin
			we_s2   <= we_s1;
			last_s2 <= last_s1;
			data_s2 <= data_s1;
			addr_s2 <= we_s1 ? addr_full[ADDR_WIDTH-1:0] : '0;
		end
	end

	assign dst.valid        = v_s2;
	assign dst.write_enable = we_s2;
	assign dst.write_addr   = addr_s2;
	assign dst.write_data   = data_s2;
	assign dst.last_pixel   = last_s2;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------

	// A suppressed write carries neither address nor data.
	a_quiet_suppress: assert property (@(posedge clk) disable iff (!arst_n)
		dst.valid && !dst.write_enable |-> dst.write_addr == '0 && dst.write_data == '0)
		else $error("suppressed beat carries address or data");

	// A begin beat restarts the source raster.
	a_begin_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && src.cmd == CMD_BEGIN |=> col_q == '0 && row_q == '0)
		else $error("begin beat did not restart the raster");

	// An empty first stage never blocks the input.
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> src.ready)
		else $error("input blocked with empty first stage");

	// A held first stage keeps its beat while the output stalls.
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !advance |=> v_s1 && $stable(we_s1) && $stable(data_s1))
		else $error("first stage lost its beat during a stall");

endmodule

`default_nettype wire

// File: test/rotated_sprite_blitter_unit_tb.sv
// ============================================================================
// rotated_sprite_blitter_unit_tb: self-checking bench for the sprite blitter
// Streams begin and pixel beats through the source channel under random
// gaps and output stalls. Every framebuffer write beat is checked against an
// in-bench placement predictor. Register writes go through the APB port
// while the block is idle, and each setting is read back.
// ============================================================================
module rotated_sprite_blitter_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rsb_pkg::*;

	localparam int ADDR_W      = ADDR_WIDTH_DEF;
	localparam int MAX_GAP     = 17;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_BEATS = 300;

	// One beat on the source channel.
	typedef struct {
		logic               cmd;
		logic signed [12:0] pos_x;
		logic signed [12:0] pos_y;
		logic [1:0]         turn;
		logic [31:0]        pixel_color;
	} sprite_beat_t;

	// One beat on the framebuffer write channel.
	typedef struct {
		logic              write_enable;
		logic [ADDR_W-1:0] write_addr;
		logic [31:0]       write_data;
		logic              last_pixel;
	} fb_write_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	rsb_in_if pixel_in ();
	rsb_out_if #(.ADDR_WIDTH(ADDR_W)) fb_out ();

	rotated_sprite_blitter_unit #(
		.MAX_SPRITE(MAX_SPRITE_DEF),
		.ADDR_WIDTH(ADDR_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.src(pixel_in),
		.dst(fb_out),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// 2 ns clock period.
	always #1 clk = ~clk;

	// Predictor state: the bench's own copy of the registers, the sprite
	// placement latched by the last begin beat, and the source raster position.
	cfg_t              model_cfg;
	logic [7:0]        raster_col;
	logic [7:0]        raster_row;
	int                centre_col;
	int                centre_row;
	logic [1:0]        spin;

	// Framebuffer writes predicted but not yet seen on the output.
	fb_write_t expected_writes[$];

	// Knobs shared by the tests and the two channel processes.
	bit src_gaps_on;
	bit stalls_on;
	int hold_request;

	int errors;
	int cycle_count;
	int begins_sent, pixels_sent, random_beats;
	int settings_used, writes_seen, sprite_ends_seen;

	// ------------------------------------------------------------------------
	// Placement predictor
	// ------------------------------------------------------------------------

	// Sprite dimensions outside 1..MAX_SPRITE are treated as the nearest limit.
	function automatic int clamp_dim(int v);
		if (v < 1)
			return 1;
		if (v > MAX_SPRITE_DEF)
			return MAX_SPRITE_DEF;
		return v;
	endfunction

	// Pixel sizes outside 2..4 bytes are treated as the nearest limit.
	function automatic int clamp_bpp(int v);
		if (v < 2)
			return 2;
		if (v > 4)
			return 4;
		return v;
	endfunction

	function automatic logic [31:0] pixel_mask(int bpp);
		case (bpp)
			2:       return 32'h0000_FFFF;
			3:       return 32'h00FF_FFFF;
			default: return 32'hFFFF_FFFF;
		endcase
	endfunction

	// Computes the write that one accepted beat causes, and advances the
	// predictor's raster position.
	function automatic fb_write_t predict_fb_write(sprite_beat_t b);
		fb_write_t   r;
		int          w, h, bpp, col, row, vx, vy, dx, dy;
		int          scr_w, scr_h, stride;
		logic [31:0] color;
		longint      addr;

		r.write_enable = 1'b0;
		r.write_addr   = '0;
		r.write_data   = '0;
		r.last_pixel   = 1'b0;

		// A begin beat latches the placement and restarts the raster; its
		// own result is all zeros.
		if (b.cmd == CMD_BEGIN) begin
			centre_col = int'(b.pos_x);
			centre_row = int'(b.pos_y);
			spin       = b.turn;
			raster_col = '0;
			raster_row = '0;
			return r;
		end

		w      = clamp_dim(int'(model_cfg.sprite_width));
		h      = clamp_dim(int'(model_cfg.sprite_height));
		bpp    = clamp_bpp(int'(model_cfg.pixel_bytes));
		scr_w  = int'(model_cfg.disp_width);
		scr_h  = int'(model_cfg.disp_height);
		stride = int'(model_cfg.line_stride_bytes);
		col    = int'(raster_col);
		row    = int'(raster_row);

		// The key is compared against the pixel after masking to pixel size.
		color = b.pixel_color & pixel_mask(bpp);

		// Offset from the pivot, then a quarter-turn rotation about the centre.
		vx = col - w / 2;
		vy = row - h / 2;
		case (spin)
			2'd1: begin
				dx = centre_col - vy;
				dy = centre_row + vx;
			end
			2'd2: begin
				dx = centre_col - vx;
				dy = centre_row - vy;
			end
			2'd3: begin
				dx = centre_col + vy;
				dy = centre_row - vx;
			end
			default: begin
				dx = centre_col + vx;
				dy = centre_row + vy;
			end
		endcase

		if (color != model_cfg.transparent_color && dx >= 0 && dy >= 0 &&
				dx < scr_w && dy < scr_h) begin
			addr = longint'(dy) * longint'(stride) + longint'(dx) * longint'(bpp);
			r.write_enable = 1'b1;
			r.write_addr   = addr[ADDR_W-1:0];
			r.write_data   = color;
		end

		// A counter already at or past the sprite edge (after a size change
		// mid-sprite) ends the row, or the sprite, right away.
		if (col + 1 >= w) begin
			col = 0;
			if (row + 1 >= h) begin
				row = 0;
				r.last_pixel = 1'b1;
			end else begin
				row++;
			end
		end else begin
			col++;
		end
		raster_col = col[7:0];
		raster_row = row[7:0];
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Beat builders; fields a beat does not use carry random bits.
	// ------------------------------------------------------------------------

	function automatic sprite_beat_t begin_beat(int x, int y, int turn);
		sprite_beat_t b;
		b.cmd         = CMD_BEGIN;
		b.pos_x       = x[12:0];
		b.pos_y       = y[12:0];
		b.turn        = turn[1:0];
		b.pixel_color = $urandom;
		return b;
	endfunction

	function automatic sprite_beat_t pixel_beat(logic [31:0] color);
		sprite_beat_t b;
		b.cmd         = CMD_PIXEL;
		b.pos_x       = 13'($urandom);
		b.pos_y       = 13'($urandom);
		b.turn        = 2'($urandom);
		b.pixel_color = color;
		return b;
	endfunction

	// ------------------------------------------------------------------------
	// Register port
	// ------------------------------------------------------------------------

	function automatic logic [31:0] cfg_field(cfg_t c, reg_idx_t idx);
		case (idx)
			REG_SCREEN_W: return 32'(c.disp_width);
			REG_SCREEN_H: return 32'(c.disp_height);
			REG_STRIDE:   return 32'(c.line_stride_bytes);
			REG_BPP:      return 32'(c.pixel_bytes);
			REG_SPRITE_W: return 32'(c.sprite_width);
			REG_SPRITE_H: return 32'(c.sprite_height);
			default:      return c.transparent_color;
		endcase
	endfunction

	// Setup cycle, then access cycle; the register takes the value at the
	// edge that ends the access cycle. The bus then idles before the task returns.
	task automatic write_reg(reg_idx_t idx, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_SCREEN_W: model_cfg.disp_width        = value[COORD_W-1:0];
			REG_SCREEN_H: model_cfg.disp_height       = value[COORD_W-1:0];
			REG_STRIDE:   model_cfg.line_stride_bytes = value[STRIDE_W-1:0];
			REG_BPP:      model_cfg.pixel_bytes       = value[BPP_W-1:0];
			REG_SPRITE_W: model_cfg.sprite_width      = value[DIMREG_W-1:0];
			REG_SPRITE_H: model_cfg.sprite_height     = value[DIMREG_W-1:0];
			REG_KEY:      model_cfg.transparent_color = value;
			default: ;
		endcase
	endtask

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
			errors++;
		end
	endfunction

	// Reads every register back and compares it with the bench's copy.
	// prdata is taken at the edge that ends the access cycle.
	task automatic check_registers();
		for (int i = 0; i <= int'(REG_KEY); i++) begin
			psel    <= 1'b1;
			penable <= 1'b0;
			pwrite  <= 1'b0;
			paddr   <= {reg_idx_t'(i), 2'b00};
			@(posedge clk);
			penable <= 1'b1;
			@(posedge clk);
			check_field($sformatf("register %0d readback", i),
				cfg_field(model_cfg, reg_idx_t'(i)), prdata);
			psel    <= 1'b0;
			penable <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic set_config(cfg_t c);
		for (int i = 0; i <= int'(REG_KEY); i++)
			write_reg(reg_idx_t'(i), cfg_field(c, reg_idx_t'(i)));
		check_registers();
		settings_used++;
	endtask

	// ------------------------------------------------------------------------
	// Source channel
	// ------------------------------------------------------------------------

	// Offers one beat after an optional random gap and returns at the edge
	// that accepts it. valid stays high when the next beat follows with no
	// gap, so it is only ever assigned once per edge.
	task automatic send_beat(sprite_beat_t b);
		int gap;
		gap = src_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			pixel_in.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pixel_in.valid       <= 1'b1;
		pixel_in.cmd         <= b.cmd;
		pixel_in.pos_x       <= b.pos_x;
		pixel_in.pos_y       <= b.pos_y;
		pixel_in.turn        <= b.turn;
		pixel_in.pixel_color <= b.pixel_color;
		do @(posedge clk); while (pixel_in.ready !== 1'b1);
		expected_writes.push_back(predict_fb_write(b));
		if (b.cmd == CMD_BEGIN)
			begins_sent++;
		else
			pixels_sent++;
	endtask

	// Stops offering beats and waits until every predicted write has come out.
	// Each source beat yields exactly one output beat, so an empty queue means
	// the block is idle and registers may be written.
	task automatic wait_idle();
		pixel_in.valid <= 1'b0;
		do @(posedge clk); while (expected_writes.size() != 0);
	endtask

	// ------------------------------------------------------------------------
	// Output channel: ready with random stalls, plus long hold-offs on request
	// ------------------------------------------------------------------------

	initial begin : fb_sink
		int wait_left;
		wait_left = 0;
		fb_out.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (fb_out.valid === 1'b1 && fb_out.ready === 1'b1)
				wait_left = stalls_on ? $urandom_range(0, MAX_GAP) : 0;
			// A long hold-off lets the pipeline fill and push back on the source.
			if (hold_request > 0) begin
				wait_left    = hold_request;
				hold_request = 0;
			end
			if (wait_left > 0) begin
				fb_out.ready <= 1'b0;
				wait_left--;
			end else begin
				fb_out.ready <= 1'b1;
			end
		end
	end

	// Every accepted output beat is matched against the oldest prediction.
	always @(posedge clk) begin
		fb_write_t want;
		if (arst_n === 1'b1 && fb_out.valid === 1'b1 && fb_out.ready === 1'b1) begin
			if (expected_writes.size() == 0) begin
				$display("%0t: unexpected write beat: expected none, actual we=%b addr=%h data=%h last=%b",
					$time, fb_out.write_enable, fb_out.write_addr, fb_out.write_data,
					fb_out.last_pixel);
				errors++;
			end else begin
				want = expected_writes.pop_front();
				check_field("write_enable", 32'(want.write_enable), 32'(fb_out.write_enable));
				check_field("write_addr", 32'(want.write_addr), 32'(fb_out.write_addr));
				check_field("write_data", want.write_data, fb_out.write_data);
				check_field("last_pixel", 32'(want.last_pixel), 32'(fb_out.last_pixel));
				if (fb_out.write_enable === 1'b1)
					writes_seen++;
				if (fb_out.last_pixel === 1'b1)
					sprite_ends_seen++;
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d writes outstanding",
				$time, cycle_count, expected_writes.size());
			$display("rotated_sprite_blitter_unit_tb: errors");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Random choices
	// ------------------------------------------------------------------------

	// Mostly screen-sized values, with zero and the full register range now
	// and then.
	function automatic int random_screen_dim();
		case ($urandom_range(0, 9))
			0:       return 0;
			1:       return 4095;
			2:       return 2048;
			3:       return $urandom_range(1, 16);
			default: return $urandom_range(1, 2048);
		endcase
	endfunction

	// Small sprites keep sets short; zero and oversized values exercise the
	// clamp.
	function automatic int random_sprite_dim();
		case ($urandom_range(0, 19))
			0:       return 0;
			1:       return $urandom_range(257, 511);
			2:       return $urandom_range(9, 256);
			default: return $urandom_range(1, 8);
		endcase
	endfunction

	function automatic cfg_t random_cfg();
		cfg_t c;
		c.disp_width  = COORD_W'(random_screen_dim());
		c.disp_height = COORD_W'(random_screen_dim());
		case ($urandom_range(0, 9))
			0:       c.line_stride_bytes = 14'h3FFF;
			1:       c.line_stride_bytes = 14'd1;
			2:       c.line_stride_bytes = STRIDE_W'($urandom_range(0, 16383));
			default: c.line_stride_bytes = STRIDE_W'($urandom_range(1, 8192));
		endcase
		c.pixel_bytes = BPP_W'(($urandom_range(0, 9) < 2) ? $urandom_range(0, 7)
			: $urandom_range(2, 4));
		c.sprite_width  = DIMREG_W'(random_sprite_dim());
		c.sprite_height = DIMREG_W'(random_sprite_dim());
		c.transparent_color = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 15);
		return c;
	endfunction

	// A centre coordinate near the visible area, or anywhere in the field.
	function automatic int random_centre(int span);
		int v;
		if ($urandom_range(0, 4) == 0)
			return int'($urandom_range(0, 8191)) - 4096;
		v = int'($urandom_range(0, span + 16)) - 8;
		return (v > 4095) ? 4095 : v;
	endfunction

	// Hits the colour key often, sometimes only in the bytes that survive
	// the pixel-size mask.
	function automatic logic [31:0] random_color(cfg_t c);
		logic [31:0] mask;
		mask = pixel_mask(clamp_bpp(int'(c.pixel_bytes)));
		case ($urandom_range(0, 9))
			0, 1:    return c.transparent_color;
			2:       return (c.transparent_color & mask) | ($urandom & ~mask);
			default: return $urandom;
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Register defaults after reset, and pixels sent before any begin beat,
	// which use the reset centre and no rotation.
	task automatic test_reset_state();
		src_gaps_on = 1'b0;
		stalls_on   = 1'b0;
		check_registers();
		send_beat(pixel_beat(32'hFFFF_FFFF));
		send_beat(pixel_beat(32'h0000_0000));
		wait_idle();
	endtask

	// Each rotation on a 1x2 sprite near the bottom edge of a 2048x2048 screen
	// with the widest stride, so rows wrap the address and one turn clips.
	// Then the extreme centre positions.
	task automatic test_rotations();
		cfg_t        c;
		logic [31:0] colors[4];
		int          k;
		colors = '{32'hFFFF_FFFF, 32'h1234_5678, 32'h0000_0000, 32'h8000_0001};
		c = '{disp_width: 12'd2048, disp_height: 12'd2048,
			line_stride_bytes: 14'h3FFF, pixel_bytes: 3'd4,
			sprite_width: 9'd1, sprite_height: 9'd2,
			transparent_color: 32'h1234_5678};
		set_config(c);
		src_gaps_on = 1'b1;
		stalls_on   = 1'b1;
		k = 0;
		for (int t = 0; t < 4; t++) begin
			send_beat(begin_beat(1000, 2047, t));
			repeat (2) begin
				send_beat(pixel_beat(colors[k % 4]));
				k++;
			end
		end
		send_beat(begin_beat(4095, -4096, 1));
		send_beat(pixel_beat(32'hFFFF_FFFF));
		send_beat(begin_beat(-4096, 4095, 3));
		send_beat(pixel_beat(32'h7FFF_FFFE));
		wait_idle();
	endtask

	// Out-of-range pixel and sprite sizes, a zero-width screen, and a key
	// that matches only after the pixel is cut to two bytes.
	task automatic test_odd_sizes();
		cfg_t c;
		c = '{disp_width: 12'd0, disp_height: 12'd5, line_stride_bytes: 14'd64,
			pixel_bytes: 3'd7, sprite_width: 9'd0, sprite_height: 9'd300,
			transparent_color: 32'h0};
		set_config(c);
		send_beat(begin_beat(0, 0, 0));
		send_beat(pixel_beat(32'hDEAD_BEEF));
		wait_idle();
		c = '{disp_width: 12'd2048, disp_height: 12'd2048, line_stride_bytes: 14'd100,
			pixel_bytes: 3'd1, sprite_width: 9'd0, sprite_height: 9'd511,
			transparent_color: 32'h0000_FF00};
		set_config(c);
		send_beat(begin_beat(10, 500, 0));
		send_beat(pixel_beat(32'hABCD_FF00));
		send_beat(pixel_beat(32'hABCD_1234));
		wait_idle();
	endtask

	// Shrinks the sprite while the raster is in the middle of it: the column
	// is then past the new width and the row past the new height.
	task automatic test_raster_overrun();
		cfg_t c;
		c = '{disp_width: 12'd64, disp_height: 12'd64, line_stride_bytes: 14'd256,
			pixel_bytes: 3'd4, sprite_width: 9'd8, sprite_height: 9'd8,
			transparent_color: 32'hFFFF_FFFF};
		set_config(c);
		send_beat(begin_beat(20, 20, 2));
		repeat (3) send_beat(pixel_beat($urandom));
		wait_idle();
		write_reg(REG_SPRITE_W, 32'd2);
		send_beat(pixel_beat($urandom));
		wait_idle();
		write_reg(REG_SPRITE_H, 32'd1);
		repeat (2) send_beat(pixel_beat($urandom));
		wait_idle();
	endtask

	// The largest sprite dimension, once as a row and once as a column.
	task automatic test_large_sprites();
		cfg_t c;
		c = '{disp_width: 12'd2048, disp_height: 12'd2048, line_stride_bytes: 14'd8192,
			pixel_bytes: 3'd3, sprite_width: 9'd256, sprite_height: 9'd1,
			transparent_color: 32'h0000_0000};
		src_gaps_on = 1'b0;
		stalls_on   = 1'b0;
		set_config(c);
		send_beat(begin_beat(1024, 100, $urandom_range(0, 3)));
		repeat (256) send_beat(pixel_beat(random_color(c)));
		wait_idle();
		c.sprite_width  = 9'd1;
		c.sprite_height = 9'd256;
		set_config(c);
		send_beat(begin_beat(100, 1024, 1));
		repeat (256) send_beat(pixel_beat(random_color(c)));
		wait_idle();
	endtask

	// The output holds off for a long stretch while the source keeps offering
	// beats back to back, so the pipeline fills and the source sees ready low.
	task automatic test_backpressure();
		cfg_t c;
		c = random_cfg();
		c.sprite_width  = 9'd4;
		c.sprite_height = 9'd4;
		set_config(c);
		src_gaps_on  = 1'b0;
		stalls_on    = 1'b0;
		hold_request = 150;
		send_beat(begin_beat(random_centre(int'(c.disp_width)),
			random_centre(int'(c.disp_height)), $urandom_range(0, 3)));
		repeat (32) send_beat(pixel_beat(random_color(c)));
		wait_idle();
	endtask

	// One register setting, then a run of sprites with random content (whole,
	// or cut at 64 pixels), sprites cut short by an early begin, and stray pixels.
	task automatic run_random_phase(int budget);
		cfg_t c;
		int   n, kind, count;
		c = random_cfg();
		set_config(c);
		src_gaps_on = ($urandom_range(0, 9) < 7);
		stalls_on   = ($urandom_range(0, 9) < 7);
		n = 0;
		while (n < budget) begin
			kind = $urandom_range(0, 9);
			if (kind == 0) begin
				send_beat(pixel_beat(random_color(c)));
				n++;
			end else begin
				send_beat(begin_beat(random_centre(int'(c.disp_width)),
					random_centre(int'(c.disp_height)), $urandom_range(0, 3)));
				n++;
				count = clamp_dim(int'(c.sprite_width)) * clamp_dim(int'(c.sprite_height));
				if (count > 64)
					count = 64;
				if (kind == 1)
					count = $urandom_range(0, count - 1);
				repeat (count) begin
					send_beat(pixel_beat(random_color(c)));
					n++;
				end
			end
		end
		wait_idle();
		random_beats += n;
	endtask

	task automatic test_random_sprites();
		while (random_beats < RANDOM_BEATS)
			run_random_phase($urandom_range(30, 90));
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------

	initial begin
		arst_n               <= 1'b0;
		psel                 <= 1'b0;
		penable              <= 1'b0;
		pwrite               <= 1'b0;
		paddr                <= '0;
		pwdata               <= '0;
		pixel_in.valid       <= 1'b0;
		pixel_in.cmd         <= CMD_BEGIN;
		pixel_in.pos_x       <= '0;
		pixel_in.pos_y       <= '0;
		pixel_in.turn        <= '0;
		pixel_in.pixel_color <= '0;

		// The predictor starts from the reset state of the block.
		model_cfg    = CFG_RESET;
		raster_col   = '0;
		raster_row   = '0;
		centre_col   = 0;
		centre_row   = 0;
		spin         = '0;
		hold_request = 0;
		errors       = 0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_rotations();
		test_odd_sizes();
		test_raster_overrun();
		test_large_sprites();
		test_backpressure();
		test_random_sprites();

		// Nothing is outstanding; the bench waits on to catch any stray beat.
		repeat (10) @(posedge clk);

		$display("Sent %0d begin and %0d pixel beats across %0d register settings,",
			begins_sent, pixels_sent, settings_used);
		$display("with %0d framebuffer writes and %0d sprite ends checked.",
			writes_seen, sprite_ends_seen);
		if (errors == 0)
			$display("rotated_sprite_blitter_unit_tb: clean");
		else
			$display("rotated_sprite_blitter_unit_tb: errors");
		$finish;
	end

endmodule

// File: files.f
rtl/rsb_pkg.sv
rtl/rsb_if.sv
rtl/rsb_cfg.sv
rtl/rotated_sprite_blitter_unit.sv
test/rotated_sprite_blitter_unit_tb.sv
